/* rtl/core/baqu_pkg.sv */
// ----------------------------------------------------------------------------
// baqu_pkg
// Shared types, register indexes and reset values for the button
// auto-repeat qualifier.
// ----------------------------------------------------------------------------
package baqu_pkg;

  localparam int BUTTON_BITS = 16;
  localparam int WORD_W      = 16;
  localparam int CFG_IDX_W   = 3;

  // Buttons above BUTTON_BITS are ignored
  localparam logic [32:0] BtnWide = (33'd1 << BUTTON_BITS) - 33'd1;
  localparam logic [WORD_W-1:0] BTN_MASK = BtnWide[WORD_W-1:0];
  localparam logic [WORD_W-1:0] CNT_MAX  = {WORD_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODIFIER_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRI_PLAIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRI_MODIFIED   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_PLAIN      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_MODIFIED   = 3'd7;

  localparam logic [WORD_W-1:0] RST_INITIAL_DELAY = 16'd15;
  localparam logic [WORD_W-1:0] RST_REPEAT_PERIOD = 16'd4;
  localparam logic [WORD_W-1:0] RST_SECOND_PERIOD = 16'd8;
  localparam logic [WORD_W-1:0] RST_MODIFIER_MASK = 16'h8000;
  localparam logic [WORD_W-1:0] RST_PRI_PLAIN     = 16'h00F0;
  localparam logic [WORD_W-1:0] RST_PRI_MODIFIED  = 16'h00A0;
  localparam logic [WORD_W-1:0] RST_SEC_PLAIN     = 16'h0C00;
  localparam logic [WORD_W-1:0] RST_SEC_MODIFIED  = 16'h0C50;

  typedef struct packed {
    logic [WORD_W-1:0] initial_delay_frames;
    logic [WORD_W-1:0] repeat_period_frames;
    logic [WORD_W-1:0] secondary_period_frames;
    logic [WORD_W-1:0] modifier_mask;
    logic [WORD_W-1:0] primary_plain_mask;
    logic [WORD_W-1:0] primary_modified_mask;
    logic [WORD_W-1:0] secondary_plain_mask;
    logic [WORD_W-1:0] secondary_modified_mask;
  } cfg_t;

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

/* rtl/core/baqu_cfg_regs.sv */
// ----------------------------------------------------------------------------
// baqu_cfg_regs
// Configuration register file: timing values and repeat masks.
// ----------------------------------------------------------------------------
module baqu_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [baqu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [baqu_pkg::WORD_W-1:0]    cfg_data,
  output baqu_pkg::cfg_t            cfg
);
  import baqu_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_delay_frames    <= RST_INITIAL_DELAY;
      cfg.repeat_period_frames    <= RST_REPEAT_PERIOD;
      cfg.secondary_period_frames <= RST_SECOND_PERIOD;
      cfg.modifier_mask           <= RST_MODIFIER_MASK;
      cfg.primary_plain_mask      <= RST_PRI_PLAIN;
      cfg.primary_modified_mask   <= RST_PRI_MODIFIED;
      cfg.secondary_plain_mask    <= RST_SEC_PLAIN;
      cfg.secondary_modified_mask <= RST_SEC_MODIFIED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INITIAL_DELAY: cfg.initial_delay_frames    <= cfg_data;
        REG_REPEAT_PERIOD: cfg.repeat_period_frames    <= cfg_data;
        REG_SECOND_PERIOD: cfg.secondary_period_frames <= cfg_data;
        REG_MODIFIER_MASK: cfg.modifier_mask           <= cfg_data;
        REG_PRI_PLAIN:     cfg.primary_plain_mask      <= cfg_data;
        REG_PRI_MODIFIED:  cfg.primary_modified_mask   <= cfg_data;
        REG_SEC_PLAIN:     cfg.secondary_plain_mask    <= cfg_data;
        REG_SEC_MODIFIED:  cfg.secondary_modified_mask <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/baqu_repeat_core.sv */
// ----------------------------------------------------------------------------
// baqu_repeat_core
// Hold and repeat counters with the single-pass event logic. The state
// advances once per item when step is high.
// ----------------------------------------------------------------------------
module baqu_repeat_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [baqu_pkg::WORD_W-1:0] buttons,
  input  baqu_pkg::cfg_t              cfg,
  output logic [baqu_pkg::WORD_W-1:0] event_bits
);
  import baqu_pkg::*;

  logic [WORD_W-1:0] last_buttons, last_buttons_next;
  logic [WORD_W-1:0] hold_count, hold_count_next;
  logic [WORD_W-1:0] primary_count, primary_count_next;
  logic [WORD_W-1:0] secondary_count, secondary_count_next;

  logic [WORD_W-1:0] btn, eligible, pri_base, sec_base, hold_inc, pri_inc, sec_inc;
  logic              modifier_held, released;

  always_comb begin
    btn           = buttons & BTN_MASK;
    eligible      = btn & (cfg.primary_plain_mask | cfg.secondary_plain_mask);
    released      = (btn == '0);
    modifier_held = |(btn & cfg.modifier_mask);
    // release of every button clears all counters
    pri_base      = released ? '0 : primary_count;
    sec_base      = released ? '0 : secondary_count;
    hold_inc      = sat_inc(hold_count);
    pri_inc       = sat_inc(pri_base);
    sec_inc       = sat_inc(sec_base);

    last_buttons_next    = btn;
    hold_count_next      = '0;
    primary_count_next   = pri_base;
    secondary_count_next = sec_base;
    event_bits           = '0;

    if (last_buttons != btn || eligible == '0) begin
      event_bits = ~last_buttons & btn;
    end else begin
      hold_count_next = hold_inc;
      // first repeat only on the frame the count steps onto the delay
      if (hold_count != CNT_MAX && hold_inc == cfg.initial_delay_frames) begin
        event_bits = eligible;
      end
      if (hold_inc >= cfg.initial_delay_frames) begin
        primary_count_next   = pri_inc;
        secondary_count_next = sec_inc;
        if (pri_inc >= cfg.repeat_period_frames) begin
          primary_count_next = '0;
          event_bits = btn & (modifier_held ? cfg.primary_modified_mask
                                            : cfg.primary_plain_mask);
        end
        if (sec_inc >= cfg.secondary_period_frames) begin
          secondary_count_next = '0;
          event_bits = event_bits | (btn & (modifier_held ? cfg.secondary_modified_mask
                                                          : cfg.secondary_plain_mask));
        end
      end else begin
        primary_count_next   = '0;
        secondary_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_buttons    <= '0;
      hold_count      <= '0;
      primary_count   <= '0;
      secondary_count <= '0;
    end else if (step) begin
      last_buttons    <= last_buttons_next;
      hold_count      <= hold_count_next;
      primary_count   <= primary_count_next;
      secondary_count <= secondary_count_next;
    end
  end

endmodule

/* rtl/core/button_auto_repeat_qualifier_unit.sv */
// ----------------------------------------------------------------------------
// button_auto_repeat_qualifier_unit
// Typematic auto-repeat for a button word: new presses and repeat pulses.
// ----------------------------------------------------------------------------
// One button word goes in per frame on the in_valid/in_ready channel and
// exactly one event word comes out on out_valid/out_ready, in order.
// The word is captured in an input register; the event logic runs in one
// pass from that register into the output register, updating the hold and
// repeat counters in the same cycle. Throughput is one item per cycle while
// the receiver takes each output word without stalling.
// When the receiver stalls, the output register holds its item and the
// input register still takes one more word; in_ready then drops until the
// output is taken. Reset (rst, synchronous) empties both registers, clears
// the counters and loads the register defaults. Configuration writes via
// cfg_we/cfg_index/cfg_data take effect on the next cycle and are meant to
// be made while no item is in flight.
// ----------------------------------------------------------------------------
module button_auto_repeat_qualifier_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [baqu_pkg::WORD_W-1:0]    buttons,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [baqu_pkg::WORD_W-1:0]    event_bits,
  input  logic                           cfg_we,
  input  logic [baqu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [baqu_pkg::WORD_W-1:0]    cfg_data
);
  import baqu_pkg::*;

  cfg_t              cfg;
  logic              in_full;
  logic [WORD_W-1:0] in_buttons;
  logic [WORD_W-1:0] event_calc;
  logic              advance;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  baqu_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  baqu_repeat_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .buttons    (in_buttons),
    .cfg        (cfg),
    .event_bits (event_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_buttons <= buttons;
    end
    if (advance) begin
      event_bits <= event_calc;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_full) |-> advance)
    else $error("input register overwritten before its item advanced");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(event_bits))
    else $error("stalled result changed or dropped");

  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item did not reach the output register");

endmodule

/* test/button_auto_repeat_checker.sv */
// ----------------------------------------------------------------------------
// button_auto_repeat_checker
// Watches the button, event and register ports of the auto-repeat
// qualifier, predicts each event word and compares it in order.
// ----------------------------------------------------------------------------
module button_auto_repeat_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [baqu_pkg::WORD_W-1:0]    buttons,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [baqu_pkg::WORD_W-1:0]    event_bits,
  input  logic                           cfg_we,
  input  logic [baqu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [baqu_pkg::WORD_W-1:0]    cfg_data,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import baqu_pkg::*;

  cfg_t              regs;
  logic [WORD_W-1:0] held_word;
  logic [WORD_W-1:0] hold_cnt;
  logic [WORD_W-1:0] pri_cnt;
  logic [WORD_W-1:0] sec_cnt;
  logic [WORD_W-1:0] event_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [WORD_W-1:0] count_up(input logic [WORD_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Advance the hold and repeat counters by one frame and return the event word
  function automatic logic [WORD_W-1:0] qualify_word(input logic [WORD_W-1:0] raw);
    logic [WORD_W-1:0] btn;
    logic [WORD_W-1:0] last;
    logic [WORD_W-1:0] elig;
    logic [WORD_W-1:0] nxt;
    logic [WORD_W-1:0] ev;
    logic              modi;
    btn  = raw & BTN_MASK;
    last = held_word;
    elig = btn & (regs.primary_plain_mask | regs.secondary_plain_mask);
    ev   = '0;
    if (btn == '0) begin
      hold_cnt = '0;
      pri_cnt  = '0;
      sec_cnt  = '0;
    end
    held_word = btn;
    if (last != btn || elig == '0) begin
      ev       = ~last & btn;
      hold_cnt = '0;
    end else begin
      nxt = count_up(hold_cnt);
      // fire the first repeat only on the step onto the delay
      if (nxt != hold_cnt && nxt == regs.initial_delay_frames) ev = elig;
      hold_cnt = nxt;
      if (nxt >= regs.initial_delay_frames) begin
        modi    = (btn & regs.modifier_mask) != '0;
        pri_cnt = count_up(pri_cnt);
        sec_cnt = count_up(sec_cnt);
        if (pri_cnt >= regs.repeat_period_frames) begin
          pri_cnt = '0;
          ev = btn & (modi ? regs.primary_modified_mask : regs.primary_plain_mask);
        end
        if (sec_cnt >= regs.secondary_period_frames) begin
          sec_cnt = '0;
          ev |= btn & (modi ? regs.secondary_modified_mask : regs.secondary_plain_mask);
        end
      end else begin
        pri_cnt = '0;
        sec_cnt = '0;
      end
    end
    return ev;
  endfunction

  always @(posedge clk) begin : watch
    logic [WORD_W-1:0] want;
    if (rst) begin
      regs = '{initial_delay_frames:    RST_INITIAL_DELAY,
               repeat_period_frames:    RST_REPEAT_PERIOD,
               secondary_period_frames: RST_SECOND_PERIOD,
               modifier_mask:           RST_MODIFIER_MASK,
               primary_plain_mask:      RST_PRI_PLAIN,
               primary_modified_mask:   RST_PRI_MODIFIED,
               secondary_plain_mask:    RST_SEC_PLAIN,
               secondary_modified_mask: RST_SEC_MODIFIED};
      held_word = '0;
      hold_cnt  = '0;
      pri_cnt   = '0;
      sec_cnt   = '0;
      event_q.delete();
    end else begin
      // compare before pushing: an item never leaves in the cycle it enters
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          errors++;
          $display("%0t: event item with none expected, expected none, actual %h",
                   $time, event_bits);
        end else begin
          want = event_q.pop_front();
          if (event_bits !== want) begin
            errors++;
            $display("%0t: event_bits mismatch, expected %h, actual %h",
                     $time, want, event_bits);
          end
        end
      end
      if (in_valid && in_ready) event_q.push_back(qualify_word(buttons));
      if (cfg_we) begin
        case (cfg_index)
          REG_INITIAL_DELAY: regs.initial_delay_frames    = cfg_data;
          REG_REPEAT_PERIOD: regs.repeat_period_frames    = cfg_data;
          REG_SECOND_PERIOD: regs.secondary_period_frames = cfg_data;
          REG_MODIFIER_MASK: regs.modifier_mask           = cfg_data;
          REG_PRI_PLAIN:     regs.primary_plain_mask      = cfg_data;
          REG_PRI_MODIFIED:  regs.primary_modified_mask   = cfg_data;
          REG_SEC_PLAIN:     regs.secondary_plain_mask    = cfg_data;
          REG_SEC_MODIFIED:  regs.secondary_modified_mask = cfg_data;
          default: ;
        endcase
      end
    end
    pending = event_q.size();
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the button auto-repeat qualifier.
// Drives button words in bursts against a stalling receiver and rewrites
// the registers between drained phases; the checker beside the block
// predicts every event word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import baqu_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [WORD_W-1:0]    buttons;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_W-1:0]    event_bits;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;
  int                   errors;
  int                   pending;

  logic [WORD_W-1:0] cur_regs [8];
  int                burst_left = 0;
  int                stall_left = 0;
  int                stall_mode = 0;

  always #4 clk = ~clk;

  button_auto_repeat_qualifier_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .buttons    (buttons),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_bits (event_bits),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  button_auto_repeat_checker event_monitor (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .buttons    (buttons),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_bits (event_bits),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending)
  );

  // Receiver: switch between stall patterns every so often
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((stall_left % 5) < 2);
    endcase
  end

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      buttons  <= WORD_W'($urandom);
    end
  endtask

  task automatic send_frame(input logic [WORD_W-1:0] w);
    if (burst_left <= 0)
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    @(negedge clk);
    in_valid <= 1'b1;
    buttons  <= w;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left == 0) hold_off($urandom_range(1, 6));
  endtask

  // Hold the sender until every event word has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_regs[idx] = val;
  endtask

  task automatic load_regs(input logic [WORD_W-1:0] dly, input logic [WORD_W-1:0] per,
                           input logic [WORD_W-1:0] sper, input logic [WORD_W-1:0] modm,
                           input logic [WORD_W-1:0] ppl, input logic [WORD_W-1:0] pmod,
                           input logic [WORD_W-1:0] spl, input logic [WORD_W-1:0] smod);
    write_reg(REG_INITIAL_DELAY, dly);
    write_reg(REG_REPEAT_PERIOD, per);
    write_reg(REG_SECOND_PERIOD, sper);
    write_reg(REG_MODIFIER_MASK, modm);
    write_reg(REG_PRI_PLAIN, ppl);
    write_reg(REG_PRI_MODIFIED, pmod);
    write_reg(REG_SEC_PLAIN, spl);
    write_reg(REG_SEC_MODIFIED, smod);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] elig;
    logic [WORD_W-1:0] w;
    elig = cur_regs[REG_PRI_PLAIN] | cur_regs[REG_SEC_PLAIN];
    case ($urandom_range(0, 7))
      0, 1, 2, 3: begin
        w = elig & WORD_W'($urandom);
        if ($urandom_range(0, 1) == 1) w |= cur_regs[REG_MODIFIER_MASK] & WORD_W'($urandom);
      end
      4:       w = elig & (16'h0001 << $urandom_range(0, 15));
      5:       w = WORD_W'($urandom);
      6:       w = 16'hFFFF;
      default: w = elig;
    endcase
    if (w == '0 && $urandom_range(0, 3) != 0) w = WORD_W'($urandom);
    return w;
  endfunction

  // Mostly held words of random length; the rest broken holds and noise
  task automatic run_sequences(input int count);
    int                sent;
    int                lim;
    int                n;
    logic [WORD_W-1:0] w;
    sent = 0;
    lim  = int'(cur_regs[REG_INITIAL_DELAY]) + int'(cur_regs[REG_REPEAT_PERIOD])
         + int'(cur_regs[REG_SECOND_PERIOD]) + 4;
    if (lim > 60) lim = 60;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          w = pick_word();
          n = $urandom_range(1, lim);
          repeat (n) send_frame(w);
          sent += n;
          if ($urandom_range(0, 2) == 0) begin
            send_frame('0);
            sent++;
          end
        end
        7: begin
          w = pick_word();
          n = $urandom_range(1, lim);
          repeat (n) send_frame(w);
          w ^= 16'h0001 << $urandom_range(0, 15);
          repeat (n) send_frame(w);
          sent += 2 * n;
        end
        default: begin
          send_frame(WORD_W'($urandom));
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    buttons   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_regs[REG_INITIAL_DELAY] = RST_INITIAL_DELAY;
    cur_regs[REG_REPEAT_PERIOD] = RST_REPEAT_PERIOD;
    cur_regs[REG_SECOND_PERIOD] = RST_SECOND_PERIOD;
    cur_regs[REG_MODIFIER_MASK] = RST_MODIFIER_MASK;
    cur_regs[REG_PRI_PLAIN]     = RST_PRI_PLAIN;
    cur_regs[REG_PRI_MODIFIED]  = RST_PRI_MODIFIED;
    cur_regs[REG_SEC_PLAIN]     = RST_SEC_PLAIN;
    cur_regs[REG_SEC_MODIFIED]  = RST_SEC_MODIFIED;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Defaults: extremes, release, a held word with nothing eligible, modifier alone
    send_frame(16'hFFFF);
    send_frame(16'h0000);
    send_frame(16'h0001);
    send_frame(16'h0001);
    send_frame(16'h8000);
    send_frame(16'h8000);
    send_frame(16'h00F0);
    send_frame(16'h0000);
    drain();

    // Short delay, primary every frame: first repeat, both timers, modifier masks
    load_regs(16'd2, 16'd0, 16'd1, RST_MODIFIER_MASK, RST_PRI_PLAIN, RST_PRI_MODIFIED,
              RST_SEC_PLAIN, RST_SEC_MODIFIED);
    repeat (4) send_frame(16'h0010);
    repeat (4) send_frame(16'h80F0);
    repeat (3) send_frame(16'h0C10);
    send_frame(16'h0000);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_regs(RST_INITIAL_DELAY, RST_REPEAT_PERIOD, RST_SECOND_PERIOD,
                     RST_MODIFIER_MASK, RST_PRI_PLAIN, RST_PRI_MODIFIED,
                     RST_SEC_PLAIN, RST_SEC_MODIFIED);
        // zero delay and periods, every button eligible and a modifier
        1: load_regs('0, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // nothing eligible: only new presses
        2: load_regs(WORD_W'($urandom_range(0, 12)), WORD_W'($urandom_range(0, 6)),
                     WORD_W'($urandom_range(0, 8)), '0, '0, '0, '0, '0);
        default: load_regs(WORD_W'($urandom_range(0, 12)), WORD_W'($urandom_range(0, 6)),
                           WORD_W'($urandom_range(0, 8)), 16'h0001 << $urandom_range(0, 15),
                           WORD_W'($urandom), WORD_W'($urandom), WORD_W'($urandom),
                           WORD_W'($urandom));
      endcase
      run_sequences(105);
      drain();
    end
    repeat (10) @(negedge clk);

    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

/* button_auto_repeat_qualifier_unit.f */
rtl/core/baqu_pkg.sv
rtl/core/baqu_cfg_regs.sv
rtl/core/baqu_repeat_core.sv
rtl/core/button_auto_repeat_qualifier_unit.sv
test/button_auto_repeat_checker.sv
test/testbench.sv
